// ===== hdl/glzw_pkg.sv =====
package glzw_pkg;

  localparam int DICT_ENTRIES = 4096;
  localparam int MAX_WIDTH    = 12;
  localparam int MAX_RESULTS  = 64;
  localparam int CODE_W       = $clog2(DICT_ENTRIES);
  localparam int NF_W         = CODE_W + 1;
  localparam int CNT_W        = $clog2(MAX_RESULTS) + 1;
  localparam int DICT_W       = CODE_W + 8;

  localparam logic [3:0] MIN_CODE_RESET = 4'd8;

  // Saturate the configured root width to 2..8.
  function automatic logic [3:0] root_bits(input logic [3:0] m);
    logic [3:0] r;
    r = m;
    if (m < 4'd2) r = 4'd2;
    if (m > 4'd8) r = 4'd8;
    return r;
  endfunction

endpackage

// ===== hdl/glzw_if.sv =====
interface glzw_code_if import glzw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code;
  modport source (output valid, output code, input ready);
  modport sink (input valid, input code, output ready);
endinterface

interface glzw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_valid;
  logic       last;
  logic       end_seen;
  logic [3:0] next_width;
  modport source (output valid, output byte_value, output byte_valid, output last,
                  output end_seen, output next_width, input ready);
  modport sink (input valid, input byte_value, input byte_valid, input last,
                input end_seen, input next_width, output ready);
endinterface

// ===== hdl/glzw_ram.sv =====
module glzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/gif_lzw_code_decoder.sv =====
// GIF LZW code decoder. Each code transfer expands to its byte string, one byte per
// output transfer, the last one flagged; clear and end codes give a single transfer
// with byte_valid low, and codes after the end are taken and dropped until reset.
// The string is built by walking the prefix chain in the dictionary memory at one
// byte per cycle onto a stack memory, then popped through the stack read port, each
// byte read in S_POP_RD once the output is free and loaded into the output register
// in S_POP_LD. Strings longer than 64 bytes show only their first 64 bytes.
// Configuration writes with paddr[2] low re-arm the clear state.
module gif_lzw_code_decoder import glzw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  glzw_code_if.sink   code_i,
  glzw_byte_if.source byte_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {S_IDLE, S_WALK, S_ROOT, S_POP_RD, S_POP_LD} state_e;

  state_e            state_q;
  logic [3:0]        min_q;
  logic [NF_W-1:0]   nf_q;
  logic [3:0]        width_q;
  logic [CODE_W-1:0] prev_code_q, c_q, code_q, ptr_q;
  logic [7:0]        prev_first_q;
  logic              await_q, fin_q, hit_q;
  logic [NF_W-1:0]   sp_q;
  logic [CNT_W-1:0]  cnt_q, n_q;

  logic       out_v_q, out_bv_q, out_last_q, out_end_q;
  logic [7:0] out_byte_q;
  logic [3:0] out_w_q;

  logic [3:0]        m;
  logic [CODE_W-1:0] clear_c, end_c;
  logic              full, accept, out_free, cfg_wr;
  logic [NF_W-1:0]   nf_inc, sp_inc;
  logic [CODE_W-1:0] start_c;
  logic              start_hit;

  logic                dict_we;
  logic [CODE_W-1:0]   dict_raddr;
  logic [DICT_W-1:0]   dict_rdata;
  logic                stk_we;
  logic [CODE_W-1:0]   stk_waddr;
  logic [7:0]          stk_wdata;
  logic [7:0]          stk_rdata;
  logic [CODE_W-1:0]   walk_next;

  assign m        = root_bits(min_q);
  assign clear_c  = CODE_W'(1) << m;
  assign end_c    = clear_c + CODE_W'(1);
  assign full     = nf_q >= NF_W'(DICT_ENTRIES);
  assign out_free = !out_v_q || byte_o.ready;
  assign code_i.ready = (state_q == S_IDLE) && out_free;
  assign accept   = code_i.valid && code_i.ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign nf_inc   = nf_q + NF_W'(1);
  assign sp_inc   = sp_q + NF_W'(1);
  assign walk_next = dict_rdata[DICT_W-1:8];

  // A code at or past the next free slot decodes as previous string plus its first byte.
  assign start_hit = !full && ({1'b0, code_i.code} >= nf_q);
  assign start_c   = start_hit ? prev_code_q : code_i.code;

  assign pready = 1'b1;
  assign prdata = {28'd0, min_q};

  assign dict_we    = (state_q == S_ROOT) && !full;
  assign dict_raddr = (state_q == S_WALK) ? walk_next : start_c;

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = sp_q[CODE_W-1:0];
    stk_wdata = c_q[7:0];
    unique case (state_q)
      S_IDLE: begin
        stk_we    = accept && !fin_q && !await_q && code_i.code != clear_c &&
                    code_i.code != end_c && start_hit;
        stk_waddr = '0;
        stk_wdata = prev_first_q;
      end
      S_WALK: begin
        stk_we    = 1'b1;
        stk_wdata = dict_rdata[7:0];
      end
      S_ROOT:   stk_we = 1'b1;
      S_POP_RD: stk_we = 1'b0;
      S_POP_LD: stk_we = 1'b0;
      default:  stk_we = 1'b0;
    endcase
  end

  glzw_ram #(.WIDTH(DICT_W), .DEPTH(DICT_ENTRIES)) u_dict (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (nf_q[CODE_W-1:0]),
    .wdata_i ({prev_code_q, c_q[7:0]}),
    .raddr_i (dict_raddr),
    .rdata_o (dict_rdata)
  );

  glzw_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (ptr_q),
    .rdata_o (stk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      min_q        <= MIN_CODE_RESET;
      nf_q         <= (NF_W'(1) << root_bits(MIN_CODE_RESET)) + NF_W'(2);
      width_q      <= root_bits(MIN_CODE_RESET) + 4'd1;
      prev_code_q  <= '0;
      prev_first_q <= '0;
      await_q      <= 1'b1;
      fin_q        <= 1'b0;
      out_v_q      <= 1'b0;
      c_q          <= '0;
      code_q       <= '0;
      ptr_q        <= '0;
      sp_q         <= '0;
      cnt_q        <= '0;
      n_q          <= '0;
      hit_q        <= 1'b0;
      out_bv_q     <= 1'b0;
      out_last_q   <= 1'b0;
      out_end_q    <= 1'b0;
      out_byte_q   <= '0;
      out_w_q      <= '0;
    end else begin
      if (out_v_q && byte_o.ready) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept && !fin_q) begin
            if (code_i.code == clear_c) begin
              nf_q       <= (NF_W'(1) << m) + NF_W'(2);
              width_q    <= m + 4'd1;
              await_q    <= 1'b1;
              out_v_q    <= 1'b1;
              out_byte_q <= '0;
              out_bv_q   <= 1'b0;
              out_last_q <= 1'b1;
              out_end_q  <= fin_q;
              out_w_q    <= m + 4'd1;
            end else if (code_i.code == end_c) begin
              fin_q      <= 1'b1;
              out_v_q    <= 1'b1;
              out_byte_q <= '0;
              out_bv_q   <= 1'b0;
              out_last_q <= 1'b1;
              out_end_q  <= 1'b1;
              out_w_q    <= width_q;
            end else if (await_q) begin
              out_v_q    <= 1'b1;
              out_last_q <= 1'b1;
              out_end_q  <= fin_q;
              out_w_q    <= width_q;
              if (code_i.code >= clear_c) begin
                out_byte_q <= '0;
                out_bv_q   <= 1'b0;
              end else begin
                await_q      <= 1'b0;
                prev_code_q  <= code_i.code;
                prev_first_q <= code_i.code[7:0];
                out_byte_q   <= code_i.code[7:0];
                out_bv_q     <= 1'b1;
              end
            end else begin
              code_q <= code_i.code;
              hit_q  <= start_hit;
              c_q    <= start_c;
              sp_q   <= start_hit ? NF_W'(1) : '0;
              state_q <= (start_c >= clear_c) ? S_WALK : S_ROOT;
            end
          end
        end
        S_WALK: begin
          // Push the suffix and follow the prefix; the next read is already issued.
          sp_q <= sp_inc;
          c_q  <= walk_next;
          if (!(walk_next >= clear_c && sp_inc < NF_W'(DICT_ENTRIES - 1))) begin
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          ptr_q   <= sp_q[CODE_W-1:0];
          cnt_q   <= '0;
          n_q     <= (sp_inc >= NF_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS)
                                                    : sp_inc[CNT_W-1:0];
          prev_first_q <= c_q[7:0];
          if (full) begin
            prev_code_q <= code_q;
          end else begin
            prev_code_q <= hit_q ? nf_q[CODE_W-1:0] : code_q;
            nf_q        <= nf_inc;
            if (width_q < 4'(MAX_WIDTH) && nf_inc < NF_W'(DICT_ENTRIES) &&
                nf_inc == (NF_W'(1) << width_q)) begin
              width_q <= width_q + 4'd1;
            end
          end
          state_q <= S_POP_RD;
        end
        S_POP_RD: begin
          if (out_free) state_q <= S_POP_LD;
        end
        S_POP_LD: begin
          out_v_q    <= 1'b1;
          out_byte_q <= stk_rdata;
          out_bv_q   <= 1'b1;
          out_last_q <= (cnt_q + CNT_W'(1)) == n_q;
          out_end_q  <= fin_q;
          out_w_q    <= width_q;
          ptr_q      <= ptr_q - CODE_W'(1);
          cnt_q      <= cnt_q + CNT_W'(1);
          state_q    <= ((cnt_q + CNT_W'(1)) == n_q) ? S_IDLE : S_POP_RD;
        end
        default: state_q <= S_IDLE;
      endcase
      if (cfg_wr && !paddr[2]) begin
        min_q   <= pwdata[3:0];
        nf_q    <= (NF_W'(1) << root_bits(pwdata[3:0])) + NF_W'(2);
        width_q <= root_bits(pwdata[3:0]) + 4'd1;
        await_q <= 1'b1;
      end
    end
  end

  assign byte_o.valid      = out_v_q;
  assign byte_o.byte_value = out_byte_q;
  assign byte_o.byte_valid = out_bv_q;
  assign byte_o.last       = out_last_q;
  assign byte_o.end_seen   = out_end_q;
  assign byte_o.next_width = out_w_q;

`ifndef SYNTHESIS
  a_width_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    width_q <= 4'(MAX_WIDTH)) else $error("code width beyond maximum");
  a_nf_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= NF_W'(DICT_ENTRIES)) else $error("next free code past dictionary");
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_bv_q |-> out_last_q) else $error("marker item without last");
  a_pop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP_LD |-> cnt_q < n_q) else $error("pop past result count");
`endif

endmodule
